>>> hw/rtl/dcae_pkg.sv
// shared types, constants and helpers for the dma channel address engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dcae_pkg;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned CountWidth = 22;
  localparam int unsigned ModeWidth  = 4;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned OutDataWidth = 104;

  // control word bit positions
  localparam int unsigned CtrlEnableBit = 31;
  localparam int unsigned CtrlIrqBit    = 30;
  localparam int unsigned CtrlWordBit   = 26;
  localparam int unsigned CtrlRepeatBit = 25;

  localparam logic [CountWidth-1:0] CountMaskSide0   = 22'h1F_FFFF;
  localparam logic [CountWidth-1:0] CountMaskWideCh  = 22'h00_FFFF;
  localparam logic [CountWidth-1:0] CountMaskNarrow  = 22'h00_3FFF;

  typedef enum logic [1:0] {
    STEP_INC = 2'd0,
    STEP_DEC = 2'd1,
    STEP_FIX = 2'd2
  } step_t;

  typedef enum logic {
    OP_CTRL_WRITE = 1'b0,
    OP_STEP       = 1'b1
  } op_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SOURCE_BASE   = 2'd0,
    CFG_DEST_BASE     = 2'd1,
    CFG_CPU_SIDE      = 2'd2,
    CFG_CHANNEL_INDEX = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                  transfer_valid;
    logic [AddrWidth-1:0]  read_addr;
    logic [AddrWidth-1:0]  write_addr;
    logic                  word_size;
    logic                  last;
    logic                  irq;
    logic                  busy_res;
    logic [ModeWidth-1:0]  start_mode;
    logic [AddrWidth-1:0]  control_readback;
  } result_t;

  // code 3 runs as increment, like code 0
  function automatic step_t decode_step(input logic [1:0] code);
    step_t s;
    case (code)
      2'd1:    s = STEP_DEC;
      2'd2:    s = STEP_FIX;
      default: s = STEP_INC;
    endcase
    return s;
  endfunction

  function automatic logic [AddrWidth-1:0] advance(input logic [AddrWidth-1:0] addr,
                                                   input step_t step,
                                                   input logic [2:0] unit);
    logic [AddrWidth-1:0] r;
    case (step)
      STEP_INC: r = addr + {{(AddrWidth-3){1'b0}}, unit};
      STEP_DEC: r = addr - {{(AddrWidth-3){1'b0}}, unit};
      default:  r = addr;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dma_channel_address_engine.sv
// dma channel address engine: one channel that turns step words into
// read/write address pairs. Input words carry operation in s_tuser (0 control
// write, 1 step) and the control word in s_tdata. Each accepted word gives
// exactly one result word on the master side; m_tuser flags a real transfer,
// m_tlast marks the final transfer of a block.
// Configuration (source base, dest base, cpu side, channel index) is written
// through cfg_we/cfg_index/cfg_data and takes effect at the next enable.
// A result is registered in the result or skid register when its input word is
// accepted. Throughput: one word per cycle while the skid register is empty; the
// channel state update is combinational add/decrement logic before the result reg.
// When the receiver stalls, one extra result is held in a skid register and
// s_tready drops only while that register is full.
// Reset (rst, synchronous) clears the control word, addresses, count and
// configuration; no result is pending afterwards.
// depends on dcae_pkg, dcae_core, dcae_out_buf
`timescale 1ns / 1ps
`default_nettype none

module dma_channel_address_engine (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [dcae_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  wire logic [dcae_pkg::CfgDataWidth-1:0]  cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [31:0]                        s_tdata,  // control_value
  input  wire logic                               s_tuser,  // operation
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // read_addr, write_addr, word_size, irq, busy_res, start_mode,
  // control_readback, one zero pad bit
  output logic [dcae_pkg::OutDataWidth-1:0]       m_tdata,
  output logic                                    m_tuser,  // transfer_valid
  output logic                                    m_tlast   // last
);
  import dcae_pkg::*;

  result_t core_result;
  result_t out_result;
  logic    accept;

  assign accept = s_tvalid && s_tready;

  dcae_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .operation     (s_tuser),
    .control_value (s_tdata),
    .result        (core_result)
  );

  dcae_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (core_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tuser = out_result.transfer_valid;
  assign m_tlast = out_result.last;
  assign m_tdata = {1'b0,
                    out_result.control_readback,
                    out_result.start_mode,
                    out_result.busy_res,
                    out_result.irq,
                    out_result.word_size,
                    out_result.write_addr,
                    out_result.read_addr};

endmodule

`default_nettype wire

>>> hw/rtl/dcae_core.sv
// channel state, configuration registers and the per-word update logic
// depends on dcae_pkg
`timescale 1ns / 1ps
`default_nettype none

module dcae_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [dcae_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  wire logic [dcae_pkg::CfgDataWidth-1:0]  cfg_data,
  input  wire logic                               accept,
  input  wire logic                               operation,
  input  wire logic [dcae_pkg::AddrWidth-1:0]     control_value,
  output dcae_pkg::result_t                       result
);
  import dcae_pkg::*;

  logic [AddrWidth-1:0]  source_base;
  logic [AddrWidth-1:0]  dest_base;
  logic                  cpu_side;
  logic [1:0]            channel_index;

  logic [AddrWidth-1:0]  control_word, control_word_next;
  logic [AddrWidth-1:0]  current_source, current_source_next;
  logic [AddrWidth-1:0]  current_dest, current_dest_next;
  logic [CountWidth-1:0] units_left, units_left_next;
  step_t                 source_step, source_step_next;
  step_t                 dest_step, dest_step_next;
  logic [ModeWidth-1:0]  mode_latched, mode_latched_next;

  logic [CountWidth-1:0] count_mask;
  logic [CountWidth-1:0] count_masked;
  logic [2:0]            unit;
  logic                  xfer;
  logic                  is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_base   <= '0;
      dest_base     <= '0;
      cpu_side      <= 1'b0;
      channel_index <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SOURCE_BASE:   source_base   <= cfg_data;
        CFG_DEST_BASE:     dest_base     <= cfg_data;
        CFG_CPU_SIDE:      cpu_side      <= cfg_data[0];
        CFG_CHANNEL_INDEX: channel_index <= cfg_data[1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    if (!cpu_side) count_mask = CountMaskSide0;
    else if (channel_index == 2'd3) count_mask = CountMaskWideCh;
    else count_mask = CountMaskNarrow;
    count_masked = control_value[CountWidth-1:0] & count_mask;
    unit = control_word[CtrlWordBit] ? 3'd4 : 3'd2;
  end

  always_comb begin
    control_word_next   = control_word;
    current_source_next = current_source;
    current_dest_next   = current_dest;
    units_left_next     = units_left;
    source_step_next    = source_step;
    dest_step_next      = dest_step;
    mode_latched_next   = mode_latched;
    xfer                = 1'b0;
    is_last             = 1'b0;

    if (op_t'(operation) == OP_CTRL_WRITE) begin
      control_word_next = control_value;
      if (!control_value[CtrlEnableBit]) begin
        units_left_next = '0;
      end else if (!control_word[CtrlEnableBit]) begin
        // rising enable: latch addresses, steps and start mode
        current_source_next = source_base;
        current_dest_next   = dest_base;
        dest_step_next      = decode_step(control_value[22:21]);
        source_step_next    = decode_step(control_value[24:23]);
        if (!cpu_side) mode_latched_next = {1'b0, control_value[29:27]};
        else mode_latched_next = {2'b10, control_value[29:28]};
        if (mode_latched_next[2:0] == 3'd0) begin
          // zero count stands for the full mask range
          units_left_next = (count_masked == '0) ? count_mask + 1'b1 : count_masked;
        end else begin
          units_left_next = '0;
        end
      end
    end else if (units_left != '0) begin
      xfer                = 1'b1;
      current_source_next = advance(current_source, source_step, unit);
      current_dest_next   = advance(current_dest, dest_step, unit);
      units_left_next     = units_left - 1'b1;
      if (units_left_next == '0) begin
        is_last = 1'b1;
        if (!control_word[CtrlRepeatBit]) control_word_next[CtrlEnableBit] = 1'b0;
      end
    end
  end

  always_comb begin
    result.transfer_valid   = xfer;
    result.read_addr        = xfer ? current_source : current_source_next;
    result.write_addr       = xfer ? current_dest : current_dest_next;
    result.word_size        = control_word_next[CtrlWordBit];
    result.last             = is_last;
    result.irq              = is_last & control_word[CtrlIrqBit];
    result.busy_res         = units_left_next != '0;
    result.start_mode       = mode_latched_next;
    result.control_readback = control_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word   <= '0;
      current_source <= '0;
      current_dest   <= '0;
      units_left     <= '0;
      source_step    <= STEP_INC;
      dest_step      <= STEP_INC;
      mode_latched   <= '0;
    end else if (accept) begin
      control_word   <= control_word_next;
      current_source <= current_source_next;
      current_dest   <= current_dest_next;
      units_left     <= units_left_next;
      source_step    <= source_step_next;
      dest_step      <= dest_step_next;
      mode_latched   <= mode_latched_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dcae_out_buf.sv
// result register with a skid stage so one more input word is taken while output stalls
// depends on dcae_pkg
`timescale 1ns / 1ps
`default_nettype none

module dcae_out_buf (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire dcae_pkg::result_t in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output dcae_pkg::result_t out_data
);
  import dcae_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (out_valid && !out_ready && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_dma_channel_address_engine.sv
// self-checking bench for the dma channel address engine: directed rows, then random
// control/step words, each result checked against a typed expectation or a built-in channel predictor
// depends on dcae_pkg and dma_channel_address_engine
`timescale 1ns / 1ps

module tb_dma_channel_address_engine;
  import dcae_pkg::*;

  localparam int unsigned RandWords = 1110;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 10;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_style_t;

  typedef struct {
    logic                 is_cfg;
    op_t                  op;
    logic [31:0]          data;
    logic [31:0]          src_base;
    logic [31:0]          dst_base;
    logic                 side;
    logic [1:0]           chan;
    logic                 typed;
    result_t              exp;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [31:0]             s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    m_tuser;
  logic                    m_tlast;

  dma_channel_address_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // channel predictor state and its copy of the configuration
  logic [31:0] cfg_src_base = '0;
  logic [31:0] cfg_dst_base = '0;
  logic        cfg_side = 1'b0;
  logic [1:0]  cfg_chan = '0;
  logic [31:0] ctl = '0;
  logic [31:0] cur_src = '0;
  logic [31:0] cur_dst = '0;
  logic [CountWidth-1:0] units = '0;
  step_t       src_step = STEP_INC;
  step_t       dst_step = STEP_INC;
  logic [ModeWidth-1:0] mode = '0;

  result_t     pending_transfers[$];
  plan_row_t   plan[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  rx_style_t   rx_style = RX_OPEN;
  int unsigned rx_left = 0;

  function automatic step_t step_of(input logic [1:0] code);
    if (code == 2'd1) return STEP_DEC;
    if (code == 2'd2) return STEP_FIX;
    return STEP_INC;
  endfunction

  function automatic logic [31:0] moved(input logic [31:0] a, input step_t s,
                                        input logic [31:0] unit);
    if (s == STEP_INC) return a + unit;
    if (s == STEP_DEC) return a - unit;
    return a;
  endfunction

  function automatic result_t next_transfer(input op_t op, input logic [31:0] val);
    result_t r;
    logic [31:0] prev;
    logic [CountWidth-1:0] mask;
    r = '0;
    if (op == OP_CTRL_WRITE) begin
      prev = ctl;
      ctl = val;
      if (!val[CtrlEnableBit]) begin
        units = '0;
      end else if (!prev[CtrlEnableBit]) begin
        // rising enable: latch bases; dest reload on mode 3 lands on the same base
        cur_src = cfg_src_base;
        cur_dst = cfg_dst_base;
        dst_step = step_of(val[22:21]);
        src_step = step_of(val[24:23]);
        mode = cfg_side ? {2'b10, val[29:28]} : {1'b0, val[29:27]};
        if (mode[2:0] == 3'd0) begin
          if (!cfg_side) mask = CountMaskSide0;
          else mask = (cfg_chan == 2'd3) ? CountMaskWideCh : CountMaskNarrow;
          units = val[CountWidth-1:0] & mask;
          if (units == '0) units = mask + 1'b1;
        end else begin
          units = '0;
        end
      end
      r.read_addr = cur_src;
      r.write_addr = cur_dst;
    end else if (units == '0) begin
      r.read_addr = cur_src;
      r.write_addr = cur_dst;
    end else begin
      r.transfer_valid = 1'b1;
      r.read_addr = cur_src;
      r.write_addr = cur_dst;
      cur_src = moved(cur_src, src_step, ctl[CtrlWordBit] ? 32'd4 : 32'd2);
      cur_dst = moved(cur_dst, dst_step, ctl[CtrlWordBit] ? 32'd4 : 32'd2);
      units = units - 1'b1;
      if (units == '0) begin
        r.last = 1'b1;
        if (!ctl[CtrlRepeatBit]) ctl[CtrlEnableBit] = 1'b0;
        r.irq = ctl[CtrlIrqBit];
      end
    end
    r.word_size = ctl[CtrlWordBit];
    r.busy_res = (units != '0);
    r.start_mode = mode;
    r.control_readback = ctl;
    return r;
  endfunction

  function automatic result_t res(input logic tv, input logic [31:0] ra, input logic [31:0] wa,
                                  input logic ws, input logic lst, input logic irq,
                                  input logic busy, input logic [3:0] md,
                                  input logic [31:0] cw);
    result_t r;
    r.transfer_valid = tv;
    r.read_addr = ra;
    r.write_addr = wa;
    r.word_size = ws;
    r.last = lst;
    r.irq = irq;
    r.busy_res = busy;
    r.start_mode = md;
    r.control_readback = cw;
    return r;
  endfunction

  task automatic row_word(input op_t op, input logic [31:0] val);
    plan_row_t p;
    p = '{op: OP_CTRL_WRITE, default: '0};
    p.op = op;
    p.data = val;
    plan.push_back(p);
  endtask

  task automatic row_typed(input op_t op, input logic [31:0] val, input result_t e);
    plan_row_t p;
    p = '{op: OP_CTRL_WRITE, default: '0};
    p.op = op;
    p.data = val;
    p.typed = 1'b1;
    p.exp = e;
    plan.push_back(p);
  endtask

  task automatic row_cfg(input logic [31:0] sb, input logic [31:0] db, input logic side,
                         input logic [1:0] ch);
    plan_row_t p;
    p = '{op: OP_CTRL_WRITE, default: '0};
    p.is_cfg = 1'b1;
    p.src_base = sb;
    p.dst_base = db;
    p.side = side;
    p.chan = ch;
    plan.push_back(p);
  endtask

  task automatic send_word(input op_t op, input logic [31:0] val, input logic typed,
                           input result_t e);
    int unsigned gap;
    result_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = next_transfer(op, val);
    pending_transfers.push_back(typed ? e : predicted);
    words_sent++;
  endtask

  task automatic quiet_bus();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_transfers.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] sb, input logic [31:0] db, input logic side,
                              input logic [1:0] ch);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SOURCE_BASE;
    cfg_data <= sb;
    @(posedge clk);
    cfg_index <= CFG_DEST_BASE;
    cfg_data <= db;
    @(posedge clk);
    cfg_index <= CFG_CPU_SIDE;
    cfg_data <= {31'd0, side};
    @(posedge clk);
    cfg_index <= CFG_CHANNEL_INDEX;
    cfg_data <= {30'd0, ch};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_src_base = sb;
    cfg_dst_base = db;
    cfg_side = side;
    cfg_chan = ch;
  endtask

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_block();
    logic [31:0] val;
    int unsigned n;
    int unsigned steps;
    int unsigned k;
    int unsigned poke_at;
    val = $urandom;
    val[CtrlEnableBit] = 1'b1;
    if (!cfg_side) val[29:27] = 3'd0;
    else val[29:28] = 2'd0;
    n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
    val[15:0] = n[15:0];
    if (!cfg_side) val[20:16] = '0;
    send_word(OP_CTRL_WRITE, val, 1'b0, '0);
    // zero count is a huge block: always cut short
    if (n == 0) steps = $urandom_range(3, 12);
    else if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, n - 1);
    else steps = n + $urandom_range(0, 2);
    poke_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, steps) : steps + 1;
    for (k = 0; k < steps; k++) begin
      if (k == poke_at) send_word(OP_CTRL_WRITE, $urandom | 32'h8000_0000, 1'b0, '0);
      send_word(OP_STEP, $urandom, 1'b0, '0);
    end
    if (n == 0 || steps < n) send_word(OP_CTRL_WRITE, $urandom & 32'h7FFF_FFFF, 1'b0, '0);
  endtask

  // receiver ready pattern, switching among open, coin, sparse and periodic styles
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (rx_left[1:0] != 2'd0);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // result checker and stall watchdog
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.transfer_valid = m_tuser;
      got.last = m_tlast;
      got.read_addr = m_tdata[31:0];
      got.write_addr = m_tdata[63:32];
      got.word_size = m_tdata[64];
      got.irq = m_tdata[65];
      got.busy_res = m_tdata[66];
      got.start_mode = m_tdata[70:67];
      got.control_readback = m_tdata[102:71];
      if (pending_transfers.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_transfers.pop_front();
        check_field("transfer_valid", 32'(want.transfer_valid), 32'(got.transfer_valid));
        check_field("read_addr", want.read_addr, got.read_addr);
        check_field("write_addr", want.write_addr, got.write_addr);
        check_field("word_size", 32'(want.word_size), 32'(got.word_size));
        check_field("last", 32'(want.last), 32'(got.last));
        check_field("irq", 32'(want.irq), 32'(got.irq));
        check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
        check_field("start_mode", 32'(want.start_mode), 32'(got.start_mode));
        check_field("control_readback", want.control_readback, got.control_readback);
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int unsigned dir_words;
    int unsigned seqs;
    int unsigned j;
    int unsigned r;
    int unsigned t;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; typed expectations where the value is obvious
    row_typed(OP_STEP, 32'h0,
              res(1'b0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0));
    row_typed(OP_CTRL_WRITE, 32'h0,
              res(1'b0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 32'h0));
    row_cfg(32'hFFFF_FFFE, 32'h0000_0001, 1'b0, 2'd0);
    // word units, irq, dest decrement, three units; source wraps through zero
    row_typed(OP_CTRL_WRITE, 32'hC420_0003,
              res(1'b0, 32'hFFFF_FFFE, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0,
                  32'hC420_0003));
    row_typed(OP_STEP, 32'hFFFF_FFFF,
              res(1'b1, 32'hFFFF_FFFE, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0,
                  32'hC420_0003));
    row_typed(OP_STEP, 32'h0,
              res(1'b1, 32'h0000_0002, 32'hFFFF_FFFD, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0,
                  32'hC420_0003));
    row_typed(OP_STEP, 32'h0,
              res(1'b1, 32'h0000_0006, 32'hFFFF_FFF9, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0,
                  32'h4420_0003));
    row_typed(OP_STEP, 32'h0,
              res(1'b0, 32'h0000_000A, 32'hFFFF_FFF5, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,
                  32'h4420_0003));
    // zero count on side 0 means the full range; abort it
    row_word(OP_CTRL_WRITE, 32'h8000_0000);
    row_word(OP_STEP, 32'h0);
    row_word(OP_CTRL_WRITE, 32'h0);
    // repeat, dest reload code, fixed source, then rewrite while busy
    row_word(OP_CTRL_WRITE, 32'h8360_0002);
    row_word(OP_CTRL_WRITE, 32'hC760_0002);
    row_word(OP_STEP, 32'h0);
    row_word(OP_STEP, 32'h0);
    row_word(OP_STEP, 32'h0);
    row_cfg(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 2'd3);
    row_word(OP_CTRL_WRITE, 32'h0);
    // triggered start on side 1 is only recorded
    row_word(OP_CTRL_WRITE, 32'h9000_0000);
    row_word(OP_STEP, 32'h0);
    row_word(OP_CTRL_WRITE, 32'h0);
    row_word(OP_CTRL_WRITE, 32'h8000_0000);
    row_word(OP_STEP, 32'h0);
    row_word(OP_CTRL_WRITE, 32'hFFFF_FFFF);
    row_word(OP_STEP, 32'h0);
    row_word(OP_CTRL_WRITE, 32'h0);
    row_cfg(32'h1234_5678, 32'h8000_0000, 1'b1, 2'd0);
    // source code 3 counts up, narrow count
    row_word(OP_CTRL_WRITE, 32'h8180_0001);
    row_word(OP_STEP, 32'h0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        quiet_bus();
        apply_config(plan[i].src_base, plan[i].dst_base, plan[i].side, plan[i].chan);
      end else begin
        send_word(plan[i].op, plan[i].data, plan[i].typed, plan[i].exp);
      end
    end
    dir_words = words_sent;

    while (words_sent < dir_words + RandWords) begin
      quiet_bus();
      apply_config(pick_base(), pick_base(), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)));
      seqs = $urandom_range(2, 6);
      for (j = 0; j < seqs; j++) begin
        send_word(OP_CTRL_WRITE, $urandom & 32'h7FFF_FFFF, 1'b0, '0);
        r = $urandom_range(0, 9);
        if (r <= 6) begin
          run_block();
        end else if (r == 7) begin
          t = $urandom;
          t[CtrlEnableBit] = 1'b1;
          if (cfg_side) t[29:28] = 2'($urandom_range(1, 3));
          else t[29:27] = 3'($urandom_range(1, 7));
          send_word(OP_CTRL_WRITE, t, 1'b0, '0);
          repeat ($urandom_range(1, 2)) send_word(OP_STEP, $urandom, 1'b0, '0);
        end else begin
          repeat ($urandom_range(1, 6))
            send_word(op_t'($urandom_range(0, 1)), $urandom, 1'b0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_transfers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
